// ===== rtl/slpg_pkg.sv =====
// ----------------------------------------------------------------------------
// slpg_pkg
// shared types, constants and register map of the status led pattern generator
// ----------------------------------------------------------------------------
package slpg_pkg;

  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned PERIOD_W    = 15;
  localparam int unsigned DUR_W       = 16;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned QUO_W       = 17;
  localparam int unsigned PROD_W      = 2 * QUO_W;
  localparam int unsigned MOD_STEPS   = PERIOD_W;
  localparam int unsigned DIV_STEPS   = QUO_W;
  localparam int unsigned CNT_W       = $clog2(DIV_STEPS);
  localparam int unsigned TICK_MS_DEF = 1;
  localparam int unsigned TICK_MS_MAX = 25;

  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = $clog2(NUM_REGS) + 2;

  localparam logic [PERIOD_W-1:0] PERIOD_MIN = 15'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 15'd20000;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF   = 2'd0,
    MODE_SOLID = 2'd1,
    MODE_PULSE = 2'd2,
    MODE_BLINK = 2'd3
  } mode_t;

  typedef enum logic [$clog2(NUM_REGS)-1:0] {
    REG_COLOR_RED   = 3'd0,
    REG_COLOR_GREEN = 3'd1,
    REG_COLOR_BLUE  = 3'd2,
    REG_PEAK        = 3'd3,
    REG_DUTY        = 3'd4,
    REG_PERIOD      = 3'd5,
    REG_MODE        = 3'd6,
    REG_FLASH_LEVEL = 3'd7
  } reg_idx_t;

  localparam logic [COLOR_W-1:0]  RST_COLOR_RED   = 8'd0;
  localparam logic [COLOR_W-1:0]  RST_COLOR_GREEN = 8'd0;
  localparam logic [COLOR_W-1:0]  RST_COLOR_BLUE  = 8'd255;
  localparam logic [COLOR_W-1:0]  RST_PEAK        = 8'd20;
  localparam logic [COLOR_W-1:0]  RST_DUTY        = 8'd128;
  localparam logic [PERIOD_W-1:0] RST_PERIOD      = 15'd250;
  localparam mode_t               RST_MODE        = MODE_BLINK;
  localparam logic [COLOR_W-1:0]  RST_FLASH_LEVEL = 8'd20;

  typedef struct packed {
    logic [COLOR_W-1:0]  color_red;
    logic [COLOR_W-1:0]  color_green;
    logic [COLOR_W-1:0]  color_blue;
    logic [COLOR_W-1:0]  peak;
    logic [COLOR_W-1:0]  duty;
    logic [PERIOD_W-1:0] period;
    mode_t               mode;
    logic [COLOR_W-1:0]  flash_level;
  } slpg_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_PHSET,
    ST_PREP,
    ST_DIV,
    ST_SQ,
    ST_PK,
    ST_BRT,
    ST_CH0,
    ST_CH1,
    ST_CH2,
    ST_CH3,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_BLINK,
    MUL_SQ,
    MUL_PEAK,
    MUL_RED,
    MUL_GREEN,
    MUL_BLUE
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     ph_set;
    logic     prep;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     brt_set;
    logic     st_red;
    logic     st_green;
    logic     st_blue;
    logic     finish;
  } slpg_cmd_t;

  typedef struct packed {
    logic phase_in_range;
    logic is_pulse;
    logic out_free;
  } slpg_sts_t;

endpackage

// ===== rtl/slpg_in_if.sv =====
// ----------------------------------------------------------------------------
// slpg_in_if
// input channel: one tick or flash start word per handshake
// ----------------------------------------------------------------------------
interface slpg_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [slpg_pkg::DUR_W-1:0]  flash_duration_ms;

  modport source (output valid, output operation, output flash_duration_ms, input ready);
  modport sink (input valid, input operation, input flash_duration_ms, output ready);
endinterface

// ===== rtl/slpg_out_if.sv =====
// ----------------------------------------------------------------------------
// slpg_out_if
// result channel: one led color word per handshake
// ----------------------------------------------------------------------------
interface slpg_out_if;
  logic                         valid;
  logic                         ready;
  logic [slpg_pkg::COLOR_W-1:0] out_red;
  logic [slpg_pkg::COLOR_W-1:0] out_green;
  logic [slpg_pkg::COLOR_W-1:0] out_blue;
  logic                         flashing;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output flashing, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input flashing, output ready);
endinterface

// ===== rtl/slpg_regs.sv =====
// ----------------------------------------------------------------------------
// slpg_regs
// apb register file holding the pattern configuration
// ----------------------------------------------------------------------------
module slpg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [slpg_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [slpg_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [slpg_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output slpg_pkg::slpg_cfg_t                 cfg
);

  slpg_pkg::slpg_cfg_t cfg_r;
  slpg_pkg::reg_idx_t  idx;
  logic                wr_en;

  assign idx    = slpg_pkg::reg_idx_t'(paddr[slpg_pkg::APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color_red   <= slpg_pkg::RST_COLOR_RED;
      cfg_r.color_green <= slpg_pkg::RST_COLOR_GREEN;
      cfg_r.color_blue  <= slpg_pkg::RST_COLOR_BLUE;
      cfg_r.peak        <= slpg_pkg::RST_PEAK;
      cfg_r.duty        <= slpg_pkg::RST_DUTY;
      cfg_r.period      <= slpg_pkg::RST_PERIOD;
      cfg_r.mode        <= slpg_pkg::RST_MODE;
      cfg_r.flash_level <= slpg_pkg::RST_FLASH_LEVEL;
    end else if (wr_en) begin
      case (idx)
        slpg_pkg::REG_COLOR_RED:   cfg_r.color_red   <= pwdata[slpg_pkg::COLOR_W-1:0];
        slpg_pkg::REG_COLOR_GREEN: cfg_r.color_green <= pwdata[slpg_pkg::COLOR_W-1:0];
        slpg_pkg::REG_COLOR_BLUE:  cfg_r.color_blue  <= pwdata[slpg_pkg::COLOR_W-1:0];
        slpg_pkg::REG_PEAK:        cfg_r.peak        <= pwdata[slpg_pkg::COLOR_W-1:0];
        slpg_pkg::REG_DUTY:        cfg_r.duty        <= pwdata[slpg_pkg::COLOR_W-1:0];
        slpg_pkg::REG_PERIOD:      cfg_r.period      <= pwdata[slpg_pkg::PERIOD_W-1:0];
        slpg_pkg::REG_MODE:        cfg_r.mode <= slpg_pkg::mode_t'(pwdata[slpg_pkg::MODE_W-1:0]);
        slpg_pkg::REG_FLASH_LEVEL: cfg_r.flash_level <= pwdata[slpg_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      slpg_pkg::REG_COLOR_RED:   prdata = slpg_pkg::APB_DATA_W'(cfg_r.color_red);
      slpg_pkg::REG_COLOR_GREEN: prdata = slpg_pkg::APB_DATA_W'(cfg_r.color_green);
      slpg_pkg::REG_COLOR_BLUE:  prdata = slpg_pkg::APB_DATA_W'(cfg_r.color_blue);
      slpg_pkg::REG_PEAK:        prdata = slpg_pkg::APB_DATA_W'(cfg_r.peak);
      slpg_pkg::REG_DUTY:        prdata = slpg_pkg::APB_DATA_W'(cfg_r.duty);
      slpg_pkg::REG_PERIOD:      prdata = slpg_pkg::APB_DATA_W'(cfg_r.period);
      slpg_pkg::REG_MODE:        prdata = slpg_pkg::APB_DATA_W'(cfg_r.mode);
      slpg_pkg::REG_FLASH_LEVEL: prdata = slpg_pkg::APB_DATA_W'(cfg_r.flash_level);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== rtl/slpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// slpg_ctrl
// sequencer for one word: phase reduce, pulse divide, multiplies, result load
// ----------------------------------------------------------------------------
module slpg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  slpg_pkg::slpg_sts_t  sts,
  output slpg_pkg::slpg_cmd_t  cmd
);

  localparam logic [slpg_pkg::CNT_W-1:0] MOD_LAST =
    slpg_pkg::CNT_W'(slpg_pkg::MOD_STEPS - 1);
  localparam logic [slpg_pkg::CNT_W-1:0] DIV_LAST =
    slpg_pkg::CNT_W'(slpg_pkg::DIV_STEPS - 1);

  slpg_pkg::state_t             state_r, state_nxt;
  logic [slpg_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slpg_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      slpg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.phase_in_range ? slpg_pkg::ST_PREP : slpg_pkg::ST_MOD;
        end
      end
      slpg_pkg::ST_MOD: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == MOD_LAST) begin
          state_nxt = slpg_pkg::ST_PHSET;
        end
      end
      slpg_pkg::ST_PHSET: begin
        cmd.ph_set = 1'b1;
        state_nxt  = slpg_pkg::ST_PREP;
      end
      slpg_pkg::ST_PREP: begin
        cmd.prep    = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = slpg_pkg::MUL_BLINK;
        cnt_nxt     = '0;
        state_nxt   = sts.is_pulse ? slpg_pkg::ST_DIV : slpg_pkg::ST_BRT;
      end
      slpg_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = slpg_pkg::ST_SQ;
        end
      end
      slpg_pkg::ST_SQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = slpg_pkg::MUL_SQ;
        state_nxt   = slpg_pkg::ST_PK;
      end
      slpg_pkg::ST_PK: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = slpg_pkg::MUL_PEAK;
        state_nxt   = slpg_pkg::ST_BRT;
      end
      slpg_pkg::ST_BRT: begin
        cmd.brt_set = 1'b1;
        state_nxt   = slpg_pkg::ST_CH0;
      end
      slpg_pkg::ST_CH0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = slpg_pkg::MUL_RED;
        state_nxt   = slpg_pkg::ST_CH1;
      end
      slpg_pkg::ST_CH1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = slpg_pkg::MUL_GREEN;
        cmd.st_red  = 1'b1;
        state_nxt   = slpg_pkg::ST_CH2;
      end
      slpg_pkg::ST_CH2: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = slpg_pkg::MUL_BLUE;
        cmd.st_green = 1'b1;
        state_nxt    = slpg_pkg::ST_CH3;
      end
      slpg_pkg::ST_CH3: begin
        cmd.st_blue = 1'b1;
        state_nxt   = slpg_pkg::ST_FIN;
      end
      slpg_pkg::ST_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = slpg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = slpg_pkg::ST_IDLE;
      end
    endcase
  end

  // a word taken always starts a sequence
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != slpg_pkg::ST_IDLE))
    else $error("accepted word did not start a sequence");

  // division never runs past its last quotient bit
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slpg_pkg::ST_DIV) |-> (cnt_r <= DIV_LAST))
    else $error("divide step count overrun");

  // result load always ends the sequence
  a_finish_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (state_r == slpg_pkg::ST_IDLE && in_ready))
    else $error("sequence did not return to idle after result load");

endmodule

// ===== rtl/slpg_dp.sv =====
// ----------------------------------------------------------------------------
// slpg_dp
// datapath: phase and flash state, shared divider, shared multiplier, output word
// ----------------------------------------------------------------------------
module slpg_dp #(
  parameter int unsigned TICK_MS = slpg_pkg::TICK_MS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  slpg_pkg::slpg_cfg_t            cfg,
  input  slpg_pkg::slpg_cmd_t            cmd,
  output slpg_pkg::slpg_sts_t            sts,
  input  logic                           in_operation,
  input  logic [slpg_pkg::DUR_W-1:0]     in_flash_duration_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [slpg_pkg::COLOR_W-1:0]   out_red,
  output logic [slpg_pkg::COLOR_W-1:0]   out_green,
  output logic [slpg_pkg::COLOR_W-1:0]   out_blue,
  output logic                           out_flashing
);

  localparam int unsigned PW = slpg_pkg::PERIOD_W;
  localparam int unsigned QW = slpg_pkg::QUO_W;
  localparam int unsigned CW = slpg_pkg::COLOR_W;
  localparam int unsigned DW = slpg_pkg::DUR_W;
  localparam logic [DW-1:0]   TICK_D  = DW'(TICK_MS);
  localparam logic [PW:0]     TICK_P  = (PW + 1)'(TICK_MS);
  localparam logic [QW-1:0]   RND_Q16 = QW'(32768);
  localparam logic [QW-1:0]   RND_255 = QW'(127);

  // x / 255 for x below 255 * 256, exact
  function automatic logic [CW-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'd1 + 17'(x[15:8]);
    return t[15:8];
  endfunction

  logic [PW-1:0]                  per_eff;
  logic [PW-1:0]                  phase_r;
  logic [DW-1:0]                  flash_left_r;
  logic                           op_r;
  logic [DW-1:0]                  dur_r;
  logic [PW-1:0]                  ph_r;
  logic [PW-1:0]                  rem_r;
  logic [QW-1:0]                  sreg_r;
  logic [slpg_pkg::PROD_W-1:0]    prod_r;
  logic [CW-1:0]                  bri_r;
  logic [CW-1:0]                  red_r, green_r, blue_r;
  logic                           out_valid_r;
  logic [CW-1:0]                  out_red_r, out_green_r, out_blue_r;
  logic                           out_flashing_r;

  logic [PW:0]                    r2;
  logic                           ge;
  logic [PW-1:0]                  x_val;
  logic [QW-1:0]                  mul_a, mul_b, mul_add;
  logic [slpg_pkg::PROD_W-1:0]    mul_p;
  logic [PW+CW-1:0]               ph255;
  logic [CW-1:0]                  bri_nxt;
  logic [DW-1:0]                  fl_eff;
  logic [PW:0]                    ph_sum;

  // clamp the configured period
  always_comb begin
    if (cfg.period < slpg_pkg::PERIOD_MIN) begin
      per_eff = slpg_pkg::PERIOD_MIN;
    end else if (cfg.period > slpg_pkg::PERIOD_MAX) begin
      per_eff = slpg_pkg::PERIOD_MAX;
    end else begin
      per_eff = cfg.period;
    end
  end

  assign sts.phase_in_range = (phase_r < per_eff);
  assign sts.is_pulse       = (cfg.mode == slpg_pkg::MODE_PULSE);
  assign sts.out_free       = !out_valid_r || out_ready;

  // restoring divide step, remainder stays below the period
  assign r2 = {rem_r, sreg_r[QW-1]};
  assign ge = (r2 >= {1'b0, per_eff});

  // triangle fold
  assign x_val = ({ph_r, 1'b0} < {1'b0, per_eff}) ? ph_r : (per_eff - ph_r);

  // shared multiplier with rounding addend
  always_comb begin
    case (cmd.mul_sel)
      slpg_pkg::MUL_BLINK: begin
        mul_a = QW'(cfg.duty);
        mul_b = QW'(per_eff);
        mul_add = '0;
      end
      slpg_pkg::MUL_SQ: begin
        mul_a = sreg_r;
        mul_b = sreg_r;
        mul_add = RND_Q16;
      end
      slpg_pkg::MUL_PEAK: begin
        mul_a = QW'(cfg.peak);
        mul_b = prod_r[32:16];
        mul_add = RND_Q16;
      end
      slpg_pkg::MUL_RED: begin
        mul_a = QW'(cfg.color_red);
        mul_b = QW'(bri_r);
        mul_add = RND_255;
      end
      slpg_pkg::MUL_GREEN: begin
        mul_a = QW'(cfg.color_green);
        mul_b = QW'(bri_r);
        mul_add = RND_255;
      end
      slpg_pkg::MUL_BLUE: begin
        mul_a = QW'(cfg.color_blue);
        mul_b = QW'(bri_r);
        mul_add = RND_255;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        mul_add = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b + slpg_pkg::PROD_W'(mul_add);

  // brightness by mode
  assign ph255 = {ph_r, {CW{1'b0}}} - (PW + CW)'(ph_r);
  always_comb begin
    case (cfg.mode)
      slpg_pkg::MODE_OFF:   bri_nxt = '0;
      slpg_pkg::MODE_SOLID: bri_nxt = cfg.peak;
      slpg_pkg::MODE_PULSE: bri_nxt = prod_r[23:16];
      slpg_pkg::MODE_BLINK: begin
        bri_nxt = ((cfg.duty != '0) && (ph255 < prod_r[PW+CW-1:0])) ? cfg.peak : '0;
      end
      default:              bri_nxt = '0;
    endcase
  end

  assign fl_eff = op_r ? dur_r : flash_left_r;
  assign ph_sum = {1'b0, ph_r} + TICK_P;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      dur_r  <= in_flash_duration_ms;
      ph_r   <= phase_r;
      rem_r  <= '0;
      sreg_r <= {phase_r, {(QW - PW){1'b0}}};
    end else if (cmd.div_step) begin
      rem_r  <= ge ? PW'(r2 - {1'b0, per_eff}) : PW'(r2);
      sreg_r <= {sreg_r[QW-2:0], ge};
    end else if (cmd.prep) begin
      rem_r  <= x_val;
      sreg_r <= QW'(per_eff[PW-1:1]);
    end
    if (cmd.ph_set) begin
      ph_r <= rem_r;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_p;
    end
    if (cmd.brt_set) begin
      bri_r <= bri_nxt;
    end
    if (cmd.st_red) begin
      red_r <= div255(prod_r[15:0]);
    end
    if (cmd.st_green) begin
      green_r <= div255(prod_r[15:0]);
    end
    if (cmd.st_blue) begin
      blue_r <= div255(prod_r[15:0]);
    end
    if (cmd.finish) begin
      out_flashing_r <= (fl_eff != '0);
      out_red_r      <= (fl_eff != '0) ? cfg.flash_level : red_r;
      out_green_r    <= (fl_eff != '0) ? '0 : green_r;
      out_blue_r     <= (fl_eff != '0) ? '0 : blue_r;
    end
  end

  // phase, flash timer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      flash_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (op_r) begin
          flash_left_r <= dur_r;
        end else begin
          flash_left_r <= (flash_left_r > TICK_D) ? (flash_left_r - TICK_D) : '0;
          phase_r <= (ph_sum >= {1'b0, per_eff}) ? PW'(ph_sum - {1'b0, per_eff})
                                                 : PW'(ph_sum);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_red      = out_red_r;
  assign out_green    = out_green_r;
  assign out_blue     = out_blue_r;
  assign out_flashing = out_flashing_r;

  // a loaded result is offered next cycle
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("result load did not raise valid");

  // flash words carry red only
  a_flash_red_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flashing_r) |-> (out_green_r == '0 && out_blue_r == '0))
    else $error("flash word has green or blue");

  // partial remainder stays below the period while dividing
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < per_eff))
    else $error("divider remainder out of range");

endmodule

// ===== rtl/status_led_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// status_led_pattern_generator
// Turns each tick word into one rgb color word for a status led. The color
// comes from the apb registers: base color, peak brightness, mode (off, solid,
// pulse, blink), blink duty and pattern period, clamped to 100..20000 ms. A
// tick word (operation 0) shows the pattern at the current phase and then
// advances the phase by TICK_MS, wrapping at the period; a flash word
// (operation 1) loads the flash timer and, when its duration is zero, shows
// the current color, without advancing anything. While the flash timer is
// nonzero the output is the flash red level with flashing set. One word is
// worked on at a time: solid, blink and off go from the phase straight to
// the multiplies, pulse first runs the 17-step restoring divider that builds
// the triangle level, and a stored phase that lies beyond a shortened period
// is first reduced through the same divider. The result sits in an output
// register, so the next word is taken while the previous one waits.
// ----------------------------------------------------------------------------
module status_led_pattern_generator #(
  parameter int unsigned TICK_MS = slpg_pkg::TICK_MS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  slpg_in_if.sink                          in_ch,
  slpg_out_if.source                       out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [slpg_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [slpg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [slpg_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  // configuration bundle shared by the datapath
  slpg_pkg::slpg_cfg_t cfg;
  // controller to datapath commands and back
  slpg_pkg::slpg_cmd_t cmd;
  slpg_pkg::slpg_sts_t sts;

  logic in_ready;

  // register file
  slpg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer, ready only between words
  slpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // arithmetic, pattern state and output register
  slpg_dp #(
    .TICK_MS (TICK_MS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_operation         (in_ch.operation),
    .in_flash_duration_ms (in_ch.flash_duration_ms),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_red              (out_ch.out_red),
    .out_green            (out_ch.out_green),
    .out_blue             (out_ch.out_blue),
    .out_flashing         (out_ch.flashing)
  );

endmodule
